### rtl/stepper_trapezoid_step_generator_assert.svh
// assertion macros used by the step generator datapath
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef STEPPER_TRAPEZOID_STEP_GENERATOR_ASSERT_SVH
`define STEPPER_TRAPEZOID_STEP_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define STG_ASSERT_IMP(name, clock, reset_n, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);
`define STG_ASSERT_NEXT(name, clock, reset_n, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STG_ASSERT_IMP(name, clock, reset_n, ante, cons, msg)
`define STG_ASSERT_NEXT(name, clock, reset_n, ante, cons, msg)
`endif
`endif

### rtl/stg_pkg.sv
// shared constants, codes and control structs of the step generator
// no dependencies
package stg_pkg;

    localparam int STEP_BITS_DEF        = 24;
    localparam int PERIOD_FRAC_BITS_DEF = 12;
    localparam int RATE_FRAC_BITS_DEF   = 48;

    localparam int PERIOD_W  = 32;
    localparam int Q_FRAC    = 40;
    localparam int Q_INT     = 11;
    localparam int Q_W       = Q_FRAC + Q_INT;
    localparam int MUL_W     = 64;
    localparam int CHUNK_W   = 32;
    localparam int ACC_W     = 2 * MUL_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS  = 2'd2;

    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_START      = 1'b1;
    localparam logic KIND_STRAIGHT = 1'b0;
    localparam logic KIND_TURN     = 1'b1;

    // period update stages: p*p, r*pp, q*q, p*f
    localparam logic [1:0] STAGE_PP = 2'd0;
    localparam logic [1:0] STAGE_RQ = 2'd1;
    localparam logic [1:0] STAGE_QQ = 2'd2;
    localparam logic [1:0] STAGE_PF = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       issue;
        logic       accum;
        logic [1:0] chunk;
        logic       finish;
        logic [1:0] stage;
    } stg_cmd_t;

    typedef struct packed {
        logic out_free;
        logic update_req;
        logic sat;
    } stg_sts_t;

endpackage

### rtl/stg_if.sv
// valid/ready channel interfaces for the step generator words
// depends on stg_pkg for the default step count width
interface stg_req_if #(
    parameter int STEP_BITS = stg_pkg::STEP_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic                        move_kind;
    logic signed [STEP_BITS-1:0] step_count;

    modport source (output valid, output operation, output move_kind, output step_count,
                    input ready);
    modport sink   (input valid, input operation, input move_kind, input step_count,
                    output ready);
endinterface

interface stg_rsp_if;
    logic valid;
    logic ready;
    logic step_pulse;
    logic right_dir_pin;
    logic left_dir_pin;
    logic busy_res;

    modport source (output valid, output step_pulse, output right_dir_pin,
                    output left_dir_pin, output busy_res, input ready);
    modport sink   (input valid, input step_pulse, input right_dir_pin,
                    input left_dir_pin, input busy_res, output ready);
endinterface

### rtl/stepper_trapezoid_step_generator.sv
// Two-motor stepper step generator with a trapezoidal ramp. A start word or a tick word
// that does not step is taken while idle and its result word is registered at once; a
// tick that steps during acceleration or deceleration also produces its result at once but
// then holds req.ready low while the next period is computed: four 64x64 products (p*p,
// r*p*p, q*q, p*f) on one shared 32x32 multiplier, each as four partial products followed
// by a drain step and a finish step; a saturated q ends it after the second product.
// A cruise step starts no period update. A new word is taken only when the result register
// is empty or its word leaves in the same clock.
// Config writes (index 0 initial period, 1 ramp factor, 2 ramp steps) take effect at once.
// top level; depends on stg_pkg, stg_if, stg_datapath and stg_ctrl
module stepper_trapezoid_step_generator #(
    parameter int STEP_BITS        = stg_pkg::STEP_BITS_DEF,
    parameter int PERIOD_FRAC_BITS = stg_pkg::PERIOD_FRAC_BITS_DEF,
    parameter int RATE_FRAC_BITS   = stg_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    stg_req_if.sink                       req,
    stg_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_FRAC_BITS-1:0]     cfg_data
);
    import stg_pkg::*;

    stg_cmd_t cmd;
    stg_sts_t sts;
    logic     ready;

    stg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stg_datapath #(
        .STEP_BITS        (STEP_BITS),
        .PERIOD_FRAC_BITS (PERIOD_FRAC_BITS),
        .RATE_FRAC_BITS   (RATE_FRAC_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_operation     (req.operation),
        .req_move_kind     (req.move_kind),
        .req_step_count    (req.step_count),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_step_pulse    (rsp.step_pulse),
        .rsp_right_dir_pin (rsp.right_dir_pin),
        .rsp_left_dir_pin  (rsp.left_dir_pin),
        .rsp_busy_res      (rsp.busy_res),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    assign req.ready = ready;

endmodule

### rtl/stg_datapath.sv
// step generator datapath: counters, period, config registers, shared multiplier
// depends on stg_pkg and stepper_trapezoid_step_generator_assert.svh
`include "stepper_trapezoid_step_generator_assert.svh"

module stg_datapath #(
    parameter int STEP_BITS        = stg_pkg::STEP_BITS_DEF,
    parameter int PERIOD_FRAC_BITS = stg_pkg::PERIOD_FRAC_BITS_DEF,
    parameter int RATE_FRAC_BITS   = stg_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  stg_pkg::stg_cmd_t               cmd,
    output stg_pkg::stg_sts_t               sts,
    input  logic                            req_operation,
    input  logic                            req_move_kind,
    input  logic signed [STEP_BITS-1:0]     req_step_count,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic                            rsp_step_pulse,
    output logic                            rsp_right_dir_pin,
    output logic                            rsp_left_dir_pin,
    output logic                            rsp_busy_res,
    input  logic                            cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [RATE_FRAC_BITS-1:0]       cfg_data
);
    import stg_pkg::*;

    localparam int EL_W   = PERIOD_W - PERIOD_FRAC_BITS;
    localparam int RAMP_W = STEP_BITS - 1;
    // alignment of r*p*p down to q's fraction
    localparam int Q_SHIFT = RATE_FRAC_BITS + 2 * PERIOD_FRAC_BITS - Q_FRAC;

    logic [PERIOD_W-1:0]       init_period_reg;
    logic [RATE_FRAC_BITS-1:0] ramp_factor_reg;
    logic [RAMP_W-1:0]         ramp_steps_reg;

    logic [STEP_BITS-1:0] target_reg;
    logic [STEP_BITS-1:0] done_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [EL_W-1:0]      elapsed_reg;
    logic                 left_fwd_reg;
    logic                 right_fwd_reg;
    logic                 decel_reg;

    logic [MUL_W-1:0] opa_reg;
    logic [MUL_W-1:0] opb_reg;
    logic [MUL_W-1:0] prod_reg;
    logic [MUL_W-1:0] prod_next;
    logic [1:0]       shift_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] prod_aligned;
    logic [Q_W-1:0]   q_reg;

    logic out_valid_reg;
    logic pulse_reg;
    logic right_pin_reg;
    logic left_pin_reg;
    logic busy_reg;

    // item evaluation
    logic [STEP_BITS-1:0] raw;
    logic                 neg;
    logic                 pos;
    logic [STEP_BITS-1:0] mag;
    logic [EL_W-1:0]      el_inc;
    logic                 busy_tick;
    logic                 fire;
    logic                 accel;
    logic                 decel;
    logic                 is_start;

    // finish stage values
    logic [Q_W-1:0]      q_sel;
    logic                sat_rq;
    logic                sat_pf;
    logic [MUL_W-1:0]    q2;
    logic [MUL_W-1:0]    f_val;
    logic [CHUNK_W-1:0]  a_chunk;
    logic [CHUNK_W-1:0]  b_chunk;
    logic                period_wr;

    always_comb
    begin
        raw      = req_step_count;
        is_start = (req_operation == OP_START);
        neg      = raw[STEP_BITS-1];
        pos      = !neg && (raw != '0);
        mag      = neg ? ((~raw) + STEP_BITS'(1)) : raw;

        el_inc    = (&elapsed_reg) ? elapsed_reg : elapsed_reg + EL_W'(1);
        busy_tick = done_reg < target_reg;
        fire      = busy_tick && ({el_inc, {PERIOD_FRAC_BITS{1'b0}}} >= period_reg);
        accel     = done_reg < {1'b0, ramp_steps_reg};
        // steps_done > target - ramp, kept unsigned
        decel     = ({1'b0, done_reg} + {2'b0, ramp_steps_reg}) > {1'b0, target_reg};
    end

    always_comb
    begin
        q_sel  = acc_reg[Q_SHIFT + Q_W - 1:Q_SHIFT];
        sat_rq = |acc_reg[ACC_W-1:Q_SHIFT + Q_W];
        sat_pf = |acc_reg[ACC_W-1:Q_FRAC + PERIOD_W];
        q2     = acc_reg[Q_FRAC + MUL_W - 1:Q_FRAC];
        if (decel_reg)
        begin
            f_val = (MUL_W'(1) << Q_FRAC) + q2 + MUL_W'(q_reg);
        end
        else
        begin
            f_val = (MUL_W'(1) << Q_FRAC) + q2 - MUL_W'(q_reg);
        end
    end

    assign sts.out_free   = !out_valid_reg || rsp_ready;
    assign sts.update_req = !is_start && fire && (accel || decel);
    assign sts.sat        = sat_rq;

    // shared multiplier: one 32x32 partial product per cycle while cmd.issue is high
    always_comb
    begin
        a_chunk   = cmd.chunk[1] ? opa_reg[MUL_W-1:CHUNK_W] : opa_reg[CHUNK_W-1:0];
        b_chunk   = cmd.chunk[0] ? opb_reg[MUL_W-1:CHUNK_W] : opb_reg[CHUNK_W-1:0];
        prod_next = MUL_W'(a_chunk) * MUL_W'(b_chunk);
        case (shift_reg)
            2'd0:    prod_aligned = {{MUL_W{1'b0}}, prod_reg};
            2'd1:    prod_aligned = {{CHUNK_W{1'b0}}, prod_reg, {CHUNK_W{1'b0}}};
            default: prod_aligned = {prod_reg, {MUL_W{1'b0}}};
        endcase
        if (cmd.issue && (cmd.chunk == 2'd0))
        begin
            acc_next = '0;
        end
        else if (cmd.accum)
        begin
            acc_next = acc_reg + prod_aligned;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            prod_reg  <= prod_next;
            shift_reg <= 2'(cmd.chunk[1]) + 2'(cmd.chunk[0]);
        end
        acc_reg <= acc_next;

        if (cmd.accept)
        begin
            opa_reg   <= MUL_W'(period_reg);
            opb_reg   <= MUL_W'(period_reg);
            decel_reg <= !accel && decel;
        end
        else if (cmd.finish)
        begin
            unique case (cmd.stage)
                STAGE_PP:
                begin
                    opa_reg <= MUL_W'(ramp_factor_reg);
                    opb_reg <= acc_reg[MUL_W-1:0];
                end
                STAGE_RQ:
                begin
                    q_reg   <= q_sel;
                    opa_reg <= MUL_W'(q_sel);
                    opb_reg <= MUL_W'(q_sel);
                end
                STAGE_QQ:
                begin
                    opa_reg <= MUL_W'(period_reg);
                    opb_reg <= f_val;
                end
                STAGE_PF:
                begin
                    opa_reg <= opa_reg;
                end
                default:
                begin
                    opa_reg <= opa_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_period_reg <= '0;
            ramp_factor_reg <= '0;
            ramp_steps_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INIT_PERIOD: init_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_RAMP_FACTOR: ramp_factor_reg <= cfg_data;
                REG_RAMP_STEPS:  ramp_steps_reg  <= cfg_data[RAMP_W-1:0];
                default:         init_period_reg <= init_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            done_reg      <= '0;
            period_reg    <= '0;
            elapsed_reg   <= '1;
            left_fwd_reg  <= 1'b0;
            right_fwd_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (is_start)
            begin
                left_fwd_reg  <= pos;
                right_fwd_reg <= (req_move_kind == KIND_TURN) ? !pos : pos;
                target_reg    <= mag;
                done_reg      <= '0;
                period_reg    <= init_period_reg;
                elapsed_reg   <= '1;
            end
            else if (fire)
            begin
                elapsed_reg <= '0;
                done_reg    <= done_reg + STEP_BITS'(1);
            end
            else
            begin
                elapsed_reg <= el_inc;
            end
        end
        else if (cmd.finish)
        begin
            if ((cmd.stage == STAGE_RQ) && sat_rq)
            begin
                period_reg <= '1;
            end
            else if (cmd.stage == STAGE_PF)
            begin
                period_reg <= sat_pf ? '1 : acc_reg[Q_FRAC + PERIOD_W - 1:Q_FRAC];
            end
        end
    end

    // result word is formed at accept time; the period update runs behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (is_start)
            begin
                pulse_reg     <= 1'b0;
                right_pin_reg <= (req_move_kind == KIND_TURN) ? !pos : pos;
                left_pin_reg  <= !pos;
                busy_reg      <= mag != '0;
            end
            else
            begin
                pulse_reg     <= fire;
                right_pin_reg <= right_fwd_reg;
                left_pin_reg  <= !left_fwd_reg;
                busy_reg      <= busy_tick;
            end
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_step_pulse    = pulse_reg;
    assign rsp_right_dir_pin = right_pin_reg;
    assign rsp_left_dir_pin  = left_pin_reg;
    assign rsp_busy_res      = busy_reg;

    assign period_wr = cmd.accept || cmd.finish;

    `STG_ASSERT_IMP(a_done_le_target, clk, rst_n, 1'b1, done_reg <= target_reg, "steps done passed target")
    `STG_ASSERT_NEXT(a_period_hold, clk, rst_n, !period_wr, $stable(period_reg), "period changed outside update")
    `STG_ASSERT_IMP(a_pulse_busy, clk, rst_n, out_valid_reg && pulse_reg, busy_reg, "step word without busy")

endmodule

### rtl/stg_ctrl.sv
// step generator controller: accepts words and sequences the period update
// depends on stg_pkg
module stg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  stg_pkg::stg_sts_t sts,
    output stg_pkg::stg_cmd_t cmd
);
    import stg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [2:0] K_LAST = 3'd4;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [2:0] k_reg;
    logic [2:0] k_next;
    logic [1:0] stage_reg;
    logic [1:0] stage_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        stage_next = stage_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.update_req)
                begin
                    state_next = S_MUL;
                    stage_next = STAGE_PP;
                    k_next     = '0;
                end
            end
            S_MUL:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == K_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // a saturated q ends the update early
                if ((stage_reg == STAGE_PF) || ((stage_reg == STAGE_RQ) && sts.sat))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MUL;
                    stage_next = stage_reg + 2'd1;
                    k_next     = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            stage_reg <= STAGE_PP;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            stage_reg <= stage_next;
        end
    end

    assign cmd.accept = accept;
    assign cmd.issue  = (state_reg == S_MUL) && (k_reg != K_LAST);
    assign cmd.accum  = (state_reg == S_MUL) && (k_reg != 3'd0);
    assign cmd.chunk  = k_reg[1:0];
    assign cmd.finish = (state_reg == S_FIN);
    assign cmd.stage  = stage_reg;

endmodule
